// ===== design/two_level_feedback_scheduler_assert.svh =====
// Assertion macros for the two-level feedback scheduler.
// Included by the top level; depends on aclk and aresetn in the including scope.
`ifndef TWO_LEVEL_FEEDBACK_SCHEDULER_ASSERT_SVH
`define TWO_LEVEL_FEEDBACK_SCHEDULER_ASSERT_SVH

// Same-cycle implication checked while out of reset.
`define TLFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked while out of reset.
`define TLFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tlfs_pkg.sv =====
// Shared types and constants of the two-level feedback scheduler.
// No dependencies.
`timescale 1ns / 1ps

package tlfs_pkg;

    localparam int ID_W   = 8;
    localparam int DATA_W = 16;
    localparam int KEY_W  = 4;

    localparam logic [1:0] LVL_EMPTY = 2'd0;
    localparam logic [1:0] LVL_UPPER = 2'd1;
    localparam logic [1:0] LVL_RR    = 2'd2;

    localparam logic [3:0] SLICE_RESET = 4'd4;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SCAN = 7'b0000010,
        ST_ARR  = 7'b0000100,
        ST_FRD  = 7'b0001000,
        ST_SEL  = 7'b0010000,
        ST_EXEC = 7'b0100000,
        ST_PUSH = 7'b1000000
    } state_t;

endpackage

// ===== design/tlfs_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tlfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/two_level_feedback_scheduler.sv =====
// Top level of the two-level feedback scheduler: control sequencer, slot flags and output.
// Depends on tlfs_pkg, tlfs_ram and two_level_feedback_scheduler_assert.svh.
`timescale 1ns / 1ps
`include "two_level_feedback_scheduler_assert.svh"

// The block takes one item at a time. Every item starts with a scan of the slot table RAM
// through its single read port, one slot per cycle, to find the most urgent upper-level
// entry and the lowest free slot. An arrival then writes its record into that free slot, if
// one was found. A tick reads the round-robin FIFO RAM head and selects; with both levels
// empty it ends there, else it executes, adding a push step when it both rotates and demotes
// into the round-robin FIFO RAM. The execute step waits until an earlier result transfers.
// Slot levels and started flags sit in flip-flops cleared at reset, so no clearing pass runs.
module two_level_feedback_scheduler #(
    parameter int MAX_PROCS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // proc_id[7:0], burst[23:8], priority_level[27:24], order_key[31:28]
    input  logic [31:0] s_tdata,
    // action[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // done_proc_id[7:0], response_time[23:8], done_time[39:24], waiting_time[55:40]
    output logic [55:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);

    localparam int IW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int T  = TIME_BITS;
    localparam int W  = ((T > 16) ? T : 16) + 1;

    localparam int ID_LSB  = 0;
    localparam int PRI_LSB = 8;
    localparam int ORD_LSB = 12;
    localparam int BUR_LSB = 16;
    localparam int REM_LSB = 32;
    localparam int ARR_LSB = 48;
    localparam int STA_LSB = 48 + T;
    localparam int REC_W   = 48 + 2 * T;

    localparam logic [T-1:0]  TIME_MAX = {T{1'b1}};
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_PROCS);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_PROCS - 1);

    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] h, input logic [CW-1:0] c);
        logic [CW+1:0] sum;
        sum = (CW+2)'(h) + (CW+2)'(c);
        if (sum >= (CW+2)'(MAX_PROCS)) begin
            sum = sum - (CW+2)'(MAX_PROCS);
        end
        return sum[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] h);
        return (h == LAST_IDX) ? '0 : h + IW'(1);
    endfunction

    tlfs_pkg::state_t state_reg, state_next;

    logic                     act_reg, act_next;
    logic [tlfs_pkg::ID_W-1:0]   id_reg, id_next;
    logic [tlfs_pkg::DATA_W-1:0] burst_reg, burst_next;
    logic [tlfs_pkg::KEY_W-1:0]  pri_reg, pri_next;
    logic [tlfs_pkg::KEY_W-1:0]  ord_reg, ord_next;

    logic [3:0]      time_slice_reg, time_slice_next;
    logic [1:0]      level_reg [MAX_PROCS];
    logic [1:0]      level_next [MAX_PROCS];
    logic            started_reg [MAX_PROCS];
    logic            started_next [MAX_PROCS];
    logic [IW-1:0]   rr_head_reg, rr_head_next;
    logic [CW-1:0]   rr_count_reg, rr_count_next;
    logic [T-1:0]    now_reg, now_next;
    logic [3:0]      slice_reg, slice_next;
    logic            rrwr_reg, rrwr_next;

    logic [CW-1:0]   scan_cnt_reg, scan_cnt_next;
    logic            rd_vld_reg, rd_vld_next;
    logic [IW-1:0]   rd_idx_reg, rd_idx_next;
    logic            best_vld_reg, best_vld_next;
    logic [IW-1:0]   best_idx_reg, best_idx_next;
    logic [3:0]      best_pri_reg, best_pri_next;
    logic [3:0]      best_ord_reg, best_ord_next;
    logic            free_vld_reg, free_vld_next;
    logic [IW-1:0]   free_idx_reg, free_idx_next;

    logic [IW-1:0]   s_reg, s_next;
    logic [IW-1:0]   fq_reg, fq_next;
    logic            upper_reg, upper_next;
    logic [IW-1:0]   push_addr_reg, push_addr_next;
    logic [IW-1:0]   push_data_reg, push_data_next;

    logic            m_tvalid_reg, m_tvalid_next;
    logic [55:0]     m_tdata_reg, m_tdata_next;

    logic             rec_wr_en, rec_rd_en;
    logic [IW-1:0]    rec_wr_addr, rec_rd_addr;
    logic [REC_W-1:0] rec_wr_data, rec_q;
    logic             fifo_wr_en, fifo_rd_en;
    logic [IW-1:0]    fifo_wr_addr, fifo_rd_addr, fifo_wr_data, fifo_q;

    logic [MAX_PROCS-1:0] rr_flag;

    logic [3:0]                  q_pri, q_ord;
    logic [tlfs_pkg::ID_W-1:0]   q_id;
    logic [tlfs_pkg::DATA_W-1:0] q_burst, q_rem;
    logic [T-1:0]                q_arr, q_start;

    assign q_id    = rec_q[ID_LSB +: 8];
    assign q_pri   = rec_q[PRI_LSB +: 4];
    assign q_ord   = rec_q[ORD_LSB +: 4];
    assign q_burst = rec_q[BUR_LSB +: 16];
    assign q_rem   = rec_q[REM_LSB +: 16];
    assign q_arr   = rec_q[ARR_LSB +: T];
    assign q_start = rec_q[STA_LSB +: T];

    tlfs_ram #(.WIDTH(REC_W), .DEPTH(MAX_PROCS)) u_slot_ram (
        .clk     (aclk),
        .wr_en   (rec_wr_en),
        .wr_addr (rec_wr_addr),
        .wr_data (rec_wr_data),
        .rd_en   (rec_rd_en),
        .rd_addr (rec_rd_addr),
        .rd_data (rec_q)
    );

    tlfs_ram #(.WIDTH(IW), .DEPTH(MAX_PROCS)) u_fifo_ram (
        .clk     (aclk),
        .wr_en   (fifo_wr_en),
        .wr_addr (fifo_wr_addr),
        .wr_data (fifo_wr_data),
        .rd_en   (fifo_rd_en),
        .rd_addr (fifo_rd_addr),
        .rd_data (fifo_q)
    );

    assign s_tready  = (state_reg == tlfs_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        for (int i = 0; i < MAX_PROCS; i++) begin
            rr_flag[i] = (level_reg[i] == tlfs_pkg::LVL_RR);
        end
    end

    always_comb begin
        logic [3:0]    eff;
        logic [3:0]    slice_v;
        logic [IW-1:0] head_v;
        logic [CW-1:0] count_v;
        logic          rot_wr, push_wr;
        logic [IW-1:0] rot_addr, rot_data;
        logic [T-1:0]  start_v, fin_v, resp_v;
        logic [15:0]   rem_v;
        logic [W-1:0]  fin_w, resp_w, tsum_w, wait_w;
        logic          done;

        state_next      = state_reg;
        act_next        = act_reg;
        id_next         = id_reg;
        burst_next      = burst_reg;
        pri_next        = pri_reg;
        ord_next        = ord_reg;
        time_slice_next = time_slice_reg;
        level_next      = level_reg;
        started_next    = started_reg;
        rr_head_next    = rr_head_reg;
        rr_count_next   = rr_count_reg;
        now_next        = now_reg;
        slice_next      = slice_reg;
        rrwr_next       = rrwr_reg;
        scan_cnt_next   = scan_cnt_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        best_vld_next   = best_vld_reg;
        best_idx_next   = best_idx_reg;
        best_pri_next   = best_pri_reg;
        best_ord_next   = best_ord_reg;
        free_vld_next   = free_vld_reg;
        free_idx_next   = free_idx_reg;
        s_next          = s_reg;
        fq_next         = fq_reg;
        upper_next      = upper_reg;
        push_addr_next  = push_addr_reg;
        push_data_next  = push_data_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;

        rec_wr_en    = 1'b0;
        rec_wr_addr  = s_reg;
        rec_wr_data  = rec_q;
        rec_rd_en    = 1'b0;
        rec_rd_addr  = scan_cnt_reg[IW-1:0];
        fifo_wr_en   = 1'b0;
        fifo_wr_addr = push_addr_reg;
        fifo_wr_data = push_data_reg;
        fifo_rd_en   = 1'b0;
        fifo_rd_addr = rr_head_reg;

        eff      = (time_slice_reg == 4'd0) ? 4'd1 : time_slice_reg;
        slice_v  = slice_reg;
        head_v   = rr_head_reg;
        count_v  = rr_count_reg;
        rot_wr   = 1'b0;
        push_wr  = 1'b0;
        rot_addr = '0;
        rot_data = '0;
        start_v  = q_start;
        rem_v    = q_rem;
        fin_v    = (now_reg < TIME_MAX) ? now_reg + T'(1) : now_reg;
        resp_v   = '0;
        fin_w    = W'(fin_v);
        resp_w   = '0;
        tsum_w   = '0;
        wait_w   = '0;
        done     = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (cfg_valid) begin
            time_slice_next = cfg_data;
        end

        unique case (state_reg)
            tlfs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    act_next      = s_tuser;
                    id_next       = s_tdata[7:0];
                    burst_next    = s_tdata[23:8];
                    pri_next      = s_tdata[27:24];
                    ord_next      = s_tdata[31:28];
                    scan_cnt_next = '0;
                    best_vld_next = 1'b0;
                    free_vld_next = 1'b0;
                    state_next    = tlfs_pkg::ST_SCAN;
                end
            end
            tlfs_pkg::ST_SCAN: begin
                if (scan_cnt_reg < COUNT_MAX) begin
                    rec_rd_en     = 1'b1;
                    rec_rd_addr   = scan_cnt_reg[IW-1:0];
                    rd_vld_next   = 1'b1;
                    rd_idx_next   = scan_cnt_reg[IW-1:0];
                    scan_cnt_next = scan_cnt_reg + CW'(1);
                end
                if (rd_vld_reg) begin
                    if (level_reg[rd_idx_reg] == tlfs_pkg::LVL_UPPER) begin
                        if (!best_vld_reg || q_pri < best_pri_reg ||
                            (q_pri == best_pri_reg && q_ord < best_ord_reg)) begin
                            best_vld_next = 1'b1;
                            best_idx_next = rd_idx_reg;
                            best_pri_next = q_pri;
                            best_ord_next = q_ord;
                        end
                    end
                    if (level_reg[rd_idx_reg] == tlfs_pkg::LVL_EMPTY && !free_vld_reg) begin
                        free_vld_next = 1'b1;
                        free_idx_next = rd_idx_reg;
                    end
                    if (rd_idx_reg == LAST_IDX) begin
                        rd_vld_next = 1'b0;
                        state_next  = act_reg ? tlfs_pkg::ST_FRD : tlfs_pkg::ST_ARR;
                    end
                end
            end
            tlfs_pkg::ST_ARR: begin
                if (free_vld_reg) begin
                    if (best_vld_reg && !rrwr_reg && slice_reg != 4'd0) begin
                        if (pri_reg < best_pri_reg) begin
                            if (rr_count_reg < COUNT_MAX) begin
                                fifo_wr_en   = 1'b1;
                                fifo_wr_addr = wrap_add(rr_head_reg, rr_count_reg);
                                fifo_wr_data = best_idx_reg;
                                rr_count_next = rr_count_reg + CW'(1);
                                level_next[best_idx_reg] = tlfs_pkg::LVL_RR;
                            end
                            slice_next = 4'd0;
                        end else if (pri_reg == best_pri_reg && ord_reg < best_ord_reg) begin
                            slice_next = 4'd0;
                        end
                    end
                    rec_wr_en   = 1'b1;
                    rec_wr_addr = free_idx_reg;
                    rec_wr_data = '0;
                    rec_wr_data[ID_LSB +: 8]   = id_reg;
                    rec_wr_data[PRI_LSB +: 4]  = pri_reg;
                    rec_wr_data[ORD_LSB +: 4]  = ord_reg;
                    rec_wr_data[BUR_LSB +: 16] = burst_reg;
                    rec_wr_data[REM_LSB +: 16] = (burst_reg != 16'd0) ? burst_reg : 16'd1;
                    rec_wr_data[ARR_LSB +: T]  = now_reg;
                    level_next[free_idx_reg]   = tlfs_pkg::LVL_UPPER;
                    started_next[free_idx_reg] = 1'b0;
                end
                state_next = tlfs_pkg::ST_IDLE;
            end
            tlfs_pkg::ST_FRD: begin
                fifo_rd_en   = 1'b1;
                fifo_rd_addr = rr_head_reg;
                state_next   = tlfs_pkg::ST_SEL;
            end
            tlfs_pkg::ST_SEL: begin
                fq_next = fifo_q;
                if (best_vld_reg) begin
                    s_next      = best_idx_reg;
                    upper_next  = 1'b1;
                    rec_rd_en   = 1'b1;
                    rec_rd_addr = best_idx_reg;
                    state_next  = tlfs_pkg::ST_EXEC;
                end else if (rr_count_reg != '0) begin
                    s_next      = fifo_q;
                    upper_next  = 1'b0;
                    rec_rd_en   = 1'b1;
                    rec_rd_addr = fifo_q;
                    state_next  = tlfs_pkg::ST_EXEC;
                end else begin
                    now_next   = fin_v;
                    state_next = tlfs_pkg::ST_IDLE;
                end
            end
            tlfs_pkg::ST_EXEC: begin
                if (!(m_tvalid_reg && !m_tready)) begin
                    if (upper_reg) begin
                        if (rrwr_reg) begin
                            if (slice_reg != 4'd0) begin
                                rot_wr   = 1'b1;
                                rot_addr = wrap_add(head_v, count_v);
                                rot_data = fq_reg;
                                head_v   = wrap_inc(head_v);
                            end
                            slice_v   = 4'd0;
                            rrwr_next = 1'b0;
                        end
                    end else begin
                        rrwr_next = 1'b1;
                    end
                    start_v = started_reg[s_reg] ? q_start : now_reg;
                    started_next[s_reg] = 1'b1;
                    rem_v   = (q_rem != 16'd0) ? q_rem - 16'd1 : 16'd0;
                    slice_v = slice_v + 4'd1;
                    done    = (rem_v == 16'd0);
                    if (done) begin
                        resp_v = (start_v > q_arr) ? start_v - q_arr : '0;
                        resp_w = W'(resp_v);
                        tsum_w = W'(q_burst) + W'(q_arr);
                        wait_w = (fin_w > tsum_w) ? fin_w - tsum_w : '0;
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = {wait_w[15:0], fin_w[15:0], resp_w[15:0], q_id};
                        level_next[s_reg]   = tlfs_pkg::LVL_EMPTY;
                        started_next[s_reg] = 1'b0;
                        slice_v = 4'd0;
                        if (!upper_reg) begin
                            head_v  = wrap_inc(head_v);
                            count_v = count_v - CW'(1);
                        end
                    end else if (slice_v >= eff) begin
                        slice_v = 4'd0;
                        if (upper_reg) begin
                            if (count_v < COUNT_MAX) begin
                                push_wr = 1'b1;
                                push_addr_next = wrap_add(head_v, count_v);
                                push_data_next = s_reg;
                                level_next[s_reg] = tlfs_pkg::LVL_RR;
                                count_v = count_v + CW'(1);
                            end
                        end else begin
                            rot_wr   = 1'b1;
                            rot_addr = wrap_add(head_v, count_v);
                            rot_data = s_reg;
                            head_v   = wrap_inc(head_v);
                        end
                    end
                    rec_wr_en   = 1'b1;
                    rec_wr_addr = s_reg;
                    rec_wr_data = rec_q;
                    rec_wr_data[REM_LSB +: 16] = rem_v;
                    rec_wr_data[STA_LSB +: T]  = start_v;
                    if (rot_wr) begin
                        fifo_wr_en   = 1'b1;
                        fifo_wr_addr = rot_addr;
                        fifo_wr_data = rot_data;
                    end else if (push_wr) begin
                        fifo_wr_en   = 1'b1;
                        fifo_wr_addr = push_addr_next;
                        fifo_wr_data = push_data_next;
                    end
                    slice_next    = slice_v;
                    rr_head_next  = head_v;
                    rr_count_next = count_v;
                    now_next      = fin_v;
                    state_next    = (rot_wr && push_wr) ? tlfs_pkg::ST_PUSH : tlfs_pkg::ST_IDLE;
                end
            end
            tlfs_pkg::ST_PUSH: begin
                fifo_wr_en   = 1'b1;
                fifo_wr_addr = push_addr_reg;
                fifo_wr_data = push_data_reg;
                state_next   = tlfs_pkg::ST_IDLE;
            end
            default: begin
                state_next = tlfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tlfs_pkg::ST_IDLE;
            time_slice_reg <= tlfs_pkg::SLICE_RESET;
            for (int i = 0; i < MAX_PROCS; i++) begin
                level_reg[i]   <= tlfs_pkg::LVL_EMPTY;
                started_reg[i] <= 1'b0;
            end
            rr_head_reg    <= '0;
            rr_count_reg   <= '0;
            now_reg        <= '0;
            slice_reg      <= '0;
            rrwr_reg       <= 1'b0;
            rd_vld_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            time_slice_reg <= time_slice_next;
            level_reg      <= level_next;
            started_reg    <= started_next;
            rr_head_reg    <= rr_head_next;
            rr_count_reg   <= rr_count_next;
            now_reg        <= now_next;
            slice_reg      <= slice_next;
            rrwr_reg       <= rrwr_next;
            rd_vld_reg     <= rd_vld_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg       <= act_next;
        id_reg        <= id_next;
        burst_reg     <= burst_next;
        pri_reg       <= pri_next;
        ord_reg       <= ord_next;
        scan_cnt_reg  <= scan_cnt_next;
        rd_idx_reg    <= rd_idx_next;
        best_vld_reg  <= best_vld_next;
        best_idx_reg  <= best_idx_next;
        best_pri_reg  <= best_pri_next;
        best_ord_reg  <= best_ord_next;
        free_vld_reg  <= free_vld_next;
        free_idx_reg  <= free_idx_next;
        s_reg         <= s_next;
        fq_reg        <= fq_next;
        upper_reg     <= upper_next;
        push_addr_reg <= push_addr_next;
        push_data_reg <= push_data_next;
        m_tdata_reg   <= m_tdata_next;
    end

    `TLFS_ASSERT_NOW(a_rr_count_bound, 1'b1, rr_count_reg <= COUNT_MAX, "rr count overflow")
    `TLFS_ASSERT_NOW(a_rr_count_match, 1'b1, $countones(rr_flag) == int'(rr_count_reg), "rr count mismatch")
    `TLFS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
    `TLFS_ASSERT_NOW(a_exec_holds, state_reg == tlfs_pkg::ST_EXEC && m_tvalid && !m_tready, !fifo_wr_en && !rec_wr_en, "exec while output stalled")

endmodule

// ===== sim/two_level_feedback_scheduler_test.sv =====
// Self-checking testbench of the two-level feedback scheduler with a scheduling predictor.
// Depends on tlfs_pkg and the two_level_feedback_scheduler RTL.
`timescale 1ns / 1ps

typedef struct packed {
    logic [15:0] waiting_time;
    logic [15:0] done_time;
    logic [15:0] response_time;
    logic [7:0]  done_proc_id;
} completion_t;

class sched_scoreboard;
    localparam int NSLOT = 16;
    localparam int TMAX = 65535;

    logic [7:0]  proc_id [NSLOT];
    int unsigned remain [NSLOT];
    int unsigned burst [NSLOT];
    logic [3:0]  prio [NSLOT];
    logic [3:0]  order [NSLOT];
    int unsigned arrive [NSLOT];
    int unsigned first_run [NSLOT];
    bit          started [NSLOT];
    logic [1:0]  level [NSLOT];
    int unsigned rr_slot [NSLOT];
    int unsigned rr_first, rr_size, now, slice_used;
    bit          rr_active;
    logic [3:0]  slice_len;
    completion_t completions [$];
    int          errors;

    function void clear();
        for (int i = 0; i < NSLOT; i++) begin
            level[i] = tlfs_pkg::LVL_EMPTY;
            started[i] = 0;
        end
        rr_first = 0;
        rr_size = 0;
        now = 0;
        slice_used = 0;
        rr_active = 0;
        slice_len = tlfs_pkg::SLICE_RESET;
        completions.delete();
        errors = 0;
    endfunction

    function int upper_head();
        int best;
        best = -1;
        for (int i = 0; i < NSLOT; i++) begin
            if (level[i] == tlfs_pkg::LVL_UPPER && (best < 0 || prio[i] < prio[best] ||
                (prio[i] == prio[best] && order[i] < order[best])))
                best = i;
        end
        return best;
    endfunction

    function void demote(int s);
        if (rr_size < NSLOT) begin
            rr_slot[(rr_first + rr_size) % NSLOT] = 32'(s);
            rr_size++;
            level[s] = tlfs_pkg::LVL_RR;
        end
    endfunction

    function void rotate();
        int unsigned s;
        if (rr_size == 0) return;
        s = rr_slot[rr_first];
        rr_first = (rr_first + 1) % NSLOT;
        rr_slot[(rr_first + rr_size - 1) % NSLOT] = s;
    endfunction

    function bit run_tick(int s);
        if (!started[s]) begin
            first_run[s] = now;
            started[s] = 1;
        end
        if (remain[s] > 0) remain[s]--;
        slice_used++;
        return remain[s] == 0;
    endfunction

    function void complete(int s);
        completion_t c;
        int unsigned fin, t;
        fin = (now < TMAX) ? now + 1 : TMAX;
        t = burst[s] + arrive[s];
        c.done_proc_id = proc_id[s];
        c.response_time = 16'((first_run[s] > arrive[s]) ? first_run[s] - arrive[s] : 0);
        c.done_time = 16'(fin);
        c.waiting_time = 16'((fin > t) ? fin - t : 0);
        completions.insert(completions.size(), c);
        level[s] = tlfs_pkg::LVL_EMPTY;
        started[s] = 0;
    endfunction

    function int unsigned eff_slice();
        return (slice_len == 4'd0) ? 1 : 32'(slice_len);
    endfunction

    function void note_item(bit is_tick, logic [31:0] d);
        int h, fs, s;
        logic [3:0] p, o;
        if (!is_tick) begin
            p = d[27:24];
            o = d[31:28];
            fs = -1;
            for (int i = NSLOT - 1; i >= 0; i--)
                if (level[i] == tlfs_pkg::LVL_EMPTY) fs = i;
            if (fs < 0) return;
            h = upper_head();
            if (h >= 0 && !rr_active && slice_used > 0) begin
                if (p < prio[h]) begin
                    demote(h);
                    slice_used = 0;
                end else if (p == prio[h] && o < order[h]) begin
                    slice_used = 0;
                end
            end
            proc_id[fs] = d[7:0];
            burst[fs] = 32'(d[23:8]);
            remain[fs] = (d[23:8] != 16'd0) ? 32'(d[23:8]) : 32'd1;
            prio[fs] = p;
            order[fs] = o;
            arrive[fs] = now;
            first_run[fs] = 0;
            started[fs] = 0;
            level[fs] = tlfs_pkg::LVL_UPPER;
            return;
        end
        h = upper_head();
        if (h >= 0) begin
            if (rr_active) begin
                if (slice_used > 0) rotate();
                slice_used = 0;
                rr_active = 0;
            end
            if (run_tick(h)) begin
                complete(h);
                slice_used = 0;
            end else if (slice_used >= eff_slice()) begin
                demote(h);
                slice_used = 0;
            end
        end else if (rr_size > 0) begin
            s = int'(rr_slot[rr_first]);
            rr_active = 1;
            if (run_tick(s)) begin
                complete(s);
                rr_first = (rr_first + 1) % NSLOT;
                rr_size--;
                slice_used = 0;
            end else if (slice_used >= eff_slice()) begin
                rotate();
                slice_used = 0;
            end
        end
        if (now < TMAX) now++;
    endfunction

    function void check_result(logic [55:0] data);
        completion_t got, want;
        got = data;
        if (completions.size() == 0) begin
            $error("unexpected completion transfer: %h", data);
            errors++;
            return;
        end
        want = completions.pop_front();
        if (got.done_proc_id !== want.done_proc_id) begin
            $error("done_proc_id: expected %0d, got %0d", want.done_proc_id, got.done_proc_id);
            errors++;
        end
        if (got.response_time !== want.response_time) begin
            $error("response_time: expected %0d, got %0d", want.response_time,
                got.response_time);
            errors++;
        end
        if (got.done_time !== want.done_time) begin
            $error("done_time: expected %0d, got %0d", want.done_time, got.done_time);
            errors++;
        end
        if (got.waiting_time !== want.waiting_time) begin
            $error("waiting_time: expected %0d, got %0d", want.waiting_time,
                got.waiting_time);
            errors++;
        end
    endfunction
endclass

module two_level_feedback_scheduler_test;
    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;

    sched_scoreboard board;
    bit gaps_on;
    int stall_left;

    two_level_feedback_scheduler uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    initial begin
        m_tready = 0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready = 0;
                stall_left--;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                m_tready = 0;
                stall_left = $urandom_range(0, 3);
            end else begin
                m_tready = 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
    end

    task automatic send_item(bit is_tick, logic [7:0] id, logic [15:0] len,
                             logic [3:0] p, logic [3:0] o);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid = 0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid = 1;
        s_tuser = is_tick;
        s_tdata = {o, p, len, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_item(is_tick, s_tdata);
        @(negedge aclk);
    endtask

    task automatic arrive(logic [7:0] id, logic [15:0] len, logic [3:0] p, logic [3:0] o);
        send_item(1'b0, id, len, p, o);
    endtask

    task automatic tick();
        send_item(1'b1, 8'($urandom), 16'($urandom), 4'($urandom), 4'($urandom));
    endtask

    task automatic write_slice(logic [3:0] v);
        s_tvalid = 0;
        while (board.completions.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        cfg_valid = 1;
        cfg_data = v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.slice_len = v;
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    task automatic random_item();
        int k;
        k = $urandom_range(0, 99);
        if (k < 38) begin
            arrive(8'($urandom), 16'($urandom_range(0, 12)), 4'($urandom_range(0, 3)),
                   4'($urandom));
        end else if (k < 42) begin
            arrive(8'($urandom), 16'($urandom_range(0, 40)), 4'($urandom), 4'($urandom));
        end else begin
            tick();
        end
    endtask

    initial begin
        board = new();
        board.clear();
        gaps_on = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tuser = 0;
        s_tdata = 0;
        cfg_valid = 0;
        cfg_data = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        tick();
        arrive(8'd0, 16'd0, 4'd15, 4'd15);
        tick();
        arrive(8'd255, 16'hFFFF, 4'd0, 4'd0);
        arrive(8'hA5, 16'h5AAA, 4'd15, 4'd15);
        tick();
        arrive(8'h5A, 16'd3, 4'd0, 4'd0);
        arrive(8'd7, 16'd2, 4'd5, 4'd9);
        tick();
        arrive(8'd8, 16'd2, 4'd5, 4'd9);
        arrive(8'd9, 16'd3, 4'd5, 4'd2);
        tick();
        arrive(8'd10, 16'd1, 4'd5, 4'd1);
        repeat (4) tick();
        arrive(8'd11, 16'd2, 4'd3, 4'd3);
        repeat (6) tick();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_slice(4'd1);
                1: write_slice(4'd15);
                2: write_slice(4'd0);
                3: write_slice(4'd2);
                4: write_slice(4'($urandom_range(1, 15)));
                5: write_slice(4'd4);
                6: write_slice(4'd3);
                default: write_slice(4'($urandom_range(0, 15)));
            endcase
            gaps_on = (ph < 7);
            if (ph == 1 || ph == 5)
                for (int i = 0; i < 18; i++)
                    arrive(8'($urandom), 16'($urandom_range(0, 6)), 4'($urandom),
                           4'($urandom));
            for (int i = 0; i < 120; i++) random_item();
            for (int n = 0; n < 24 && (board.upper_head() >= 0 || board.rr_size > 2); n++)
                tick();
        end

        s_tvalid = 0;
        while (board.completions.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (board.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+design
design/tlfs_pkg.sv
design/tlfs_ram.sv
design/two_level_feedback_scheduler.sv
sim/two_level_feedback_scheduler_test.sv
